// ===== hdl/touch_short_long_press_detector_defines.svh =====
// assertion helpers for the press detector checker
`ifndef TOUCH_SHORT_LONG_PRESS_DETECTOR_DEFINES_SVH
`define TOUCH_SHORT_LONG_PRESS_DETECTOR_DEFINES_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define TSLPD_AST_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("press detector check failed");

// next-cycle implication, sampled on i_clk, off during reset
`define TSLPD_AST_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("press detector check failed");

`endif

// ===== hdl/tslpd_pkg.sv =====
package tslpd_pkg;

    localparam int CFG_W = 16;
    localparam int IDX_W = 3;

    typedef enum logic [IDX_W-1:0] {
        CFG_DEBOUNCE  = 3'd0,
        CFG_LONG      = 3'd1,
        CFG_GUARD     = 3'd2,
        CFG_FRAME     = 3'd3,
        CFG_ACTIVE    = 3'd4
    } t_cfg_idx;

    localparam logic [CFG_W-1:0] RST_DEBOUNCE = 16'd50;
    localparam logic [CFG_W-1:0] RST_LONG     = 16'd2000;
    localparam logic [CFG_W-1:0] RST_GUARD    = 16'd120;
    localparam logic [CFG_W-1:0] RST_FRAME    = 16'd220;
    localparam logic             RST_ACTIVE   = 1'b1;

    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] long_press_ticks;
        logic [CFG_W-1:0] release_guard_ticks;
        logic [CFG_W-1:0] frame_ticks;
        logic             active_level;
    } t_cfg;

    typedef struct packed {
        logic       led_on;
        logic       short_press;
        logic       long_press;
        logic       wake_request;
        logic       dialog_exit;
        logic       interaction;
        logic       clear_bubble;
        logic       frame_show;
        logic [1:0] frame_index;
        logic       dialog_active;
    } t_result;

endpackage

// ===== hdl/tslpd_cfg.sv =====
module tslpd_cfg (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [tslpd_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [tslpd_pkg::CFG_W-1:0] i_cfg_data,
    output tslpd_pkg::t_cfg           o_cfg
);
    import tslpd_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ticks      <= RST_DEBOUNCE;
            r_cfg.long_press_ticks    <= RST_LONG;
            r_cfg.release_guard_ticks <= RST_GUARD;
            r_cfg.frame_ticks         <= RST_FRAME;
            r_cfg.active_level        <= RST_ACTIVE;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DEBOUNCE: r_cfg.debounce_ticks      <= i_cfg_data;
                CFG_LONG:     r_cfg.long_press_ticks    <= i_cfg_data;
                CFG_GUARD:    r_cfg.release_guard_ticks <= i_cfg_data;
                CFG_FRAME:    r_cfg.frame_ticks         <= i_cfg_data;
                CFG_ACTIVE:   r_cfg.active_level        <= i_cfg_data[0];
                default:      ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/tslpd_core.sv =====
module tslpd_core #(
    parameter int CW = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic               i_raw,
    input  logic               i_sleep,
    input  tslpd_pkg::t_cfg    i_cfg,
    output tslpd_pkg::t_result o_res
);
    import tslpd_pkg::*;

    localparam int CMP_W = (CW > CFG_W) ? CW : CFG_W;
    localparam logic [CW-1:0] CNT_MAX = '1;

    function automatic logic ge(input logic [CW-1:0] c, input logic [CFG_W-1:0] t);
        return CMP_W'(c) >= CMP_W'(t);
    endfunction

    function automatic logic [CW-1:0] bump(input logic [CW-1:0] c);
        return (c == CNT_MAX) ? c : c + CW'(1);
    endfunction

    logic          r_last, r_stable, r_pressed, r_long, r_rearm, r_dialog;
    logic [1:0]    r_anim;
    logic [CW-1:0] r_src, r_srel, r_pd, r_sf;

    logic          n_last, n_stable, n_pressed, n_long, n_rearm, n_dialog;
    logic [1:0]    n_anim;
    logic [CW-1:0] n_src, n_srel, n_pd, n_sf;
    logic          active, idle;
    t_result       res;

    always_comb begin
        n_last    = r_last;
        n_stable  = r_stable;
        n_pressed = r_pressed;
        n_long    = r_long;
        n_rearm   = r_rearm;
        n_dialog  = r_dialog;
        n_anim    = r_anim;
        n_src     = bump(r_src);
        n_srel    = bump(r_srel);
        n_pd      = bump(r_pd);
        n_sf      = bump(r_sf);
        res       = '0;

        if (i_raw != r_last) begin
            n_last = i_raw;
            n_src  = '0;
        end
        if (ge(n_src, i_cfg.debounce_ticks)) begin
            n_stable = i_raw;
        end

        if (r_dialog && !i_sleep && ge(n_sf, i_cfg.frame_ticks)) begin
            n_sf           = '0;
            n_anim         = r_anim + 2'd1;
            res.frame_show = 1'b1;
        end

        active = (n_stable == i_cfg.active_level);
        idle   = !active;

        if (r_rearm) begin
            // wait for release after wake or long press
            if (idle) begin
                n_rearm   = 1'b0;
                n_pressed = 1'b0;
                n_long    = 1'b0;
                n_pd      = '0;
                n_srel    = '0;
            end
        end else begin
            if (idle) begin
                n_srel = '0;
            end
            if (r_dialog) begin
                if (active && !r_pressed) begin
                    if (ge(n_srel, i_cfg.release_guard_ticks)) begin
                        n_pressed       = 1'b1;
                        n_long          = 1'b0;
                        n_pd            = '0;
                        res.interaction = 1'b1;
                    end
                end else if (idle && r_pressed) begin
                    n_pressed       = 1'b0;
                    n_long          = 1'b0;
                    n_pd            = '0;
                    n_srel          = '0;
                    n_dialog        = 1'b0;
                    n_anim          = 2'd0;
                    n_sf            = '0;
                    res.dialog_exit = 1'b1;
                    res.interaction = 1'b1;
                end
            end else if (active && !r_pressed) begin
                if (ge(n_srel, i_cfg.release_guard_ticks)) begin
                    res.interaction = 1'b1;
                    n_long          = 1'b0;
                    n_pd            = '0;
                    if (i_sleep) begin
                        res.wake_request = 1'b1;
                        n_rearm          = 1'b1;
                        n_pressed        = 1'b0;
                    end else begin
                        n_pressed = 1'b1;
                    end
                end
            end else if (active && r_pressed) begin
                if (!r_long && ge(n_pd, i_cfg.long_press_ticks)) begin
                    n_long           = 1'b1;
                    n_dialog         = 1'b1;
                    n_anim           = 2'd0;
                    n_sf             = '0;
                    n_rearm          = 1'b1;
                    res.clear_bubble = 1'b1;
                    res.frame_show   = 1'b1;
                    res.interaction  = 1'b1;
                    res.long_press   = 1'b1;
                end
            end else if (idle && r_pressed) begin
                if (!r_long) begin
                    res.short_press = 1'b1;
                    res.interaction = 1'b1;
                end
                n_pressed = 1'b0;
                n_long    = 1'b0;
                n_pd      = '0;
                n_srel    = '0;
            end
        end

        res.led_on        = n_pressed && !n_long;
        res.frame_index   = n_anim;
        res.dialog_active = n_dialog;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last    <= !RST_ACTIVE;
            r_stable  <= !RST_ACTIVE;
            r_pressed <= 1'b0;
            r_long    <= 1'b0;
            r_rearm   <= 1'b0;
            r_dialog  <= 1'b0;
            r_anim    <= 2'd0;
            r_src     <= '0;
            r_srel    <= '0;
            r_pd      <= '0;
            r_sf      <= '0;
        end else if (i_step) begin
            r_last    <= n_last;
            r_stable  <= n_stable;
            r_pressed <= n_pressed;
            r_long    <= n_long;
            r_rearm   <= n_rearm;
            r_dialog  <= n_dialog;
            r_anim    <= n_anim;
            r_src     <= n_src;
            r_srel    <= n_srel;
            r_pd      <= n_pd;
            r_sf      <= n_sf;
        end
    end

    assign o_res = res;

endmodule

// ===== hdl/touch_short_long_press_detector.sv =====
// an item taken into the input register reaches the result register when the output is free
// throughput: one item per cycle unless stalled; all state updates in one pass of the core logic
// a stalled result holds while the input register still takes one more item
// reset (i_rst_n low, synchronous) restores default config, idle levels, zero counters and flags
module touch_short_long_press_detector #(
    parameter int COUNTER_WIDTH = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [tslpd_pkg::IDX_W-1:0] i_cfg_idx,
    input  logic [tslpd_pkg::CFG_W-1:0] i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_raw_touch,
    input  logic                        i_plant_sleeping,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_led_on,
    output logic                        o_short_press,
    output logic                        o_long_press,
    output logic                        o_wake_request,
    output logic                        o_dialog_exit,
    output logic                        o_interaction,
    output logic                        o_clear_bubble,
    output logic                        o_frame_show,
    output logic [1:0]                  o_frame_index,
    output logic                        o_dialog_active
);
    import tslpd_pkg::*;

    t_cfg    cfg;
    t_result core_res;
    t_result r_out;
    logic    r_in_valid, r_in_raw, r_in_sleep, r_out_valid;
    logic    out_free, step, in_take;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    tslpd_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    tslpd_core #(.CW(COUNTER_WIDTH)) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_raw   (r_in_raw),
        .i_sleep (r_in_sleep),
        .i_cfg   (cfg),
        .o_res   (core_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (step) begin
                r_in_valid <= 1'b0;
            end
            if (step) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
        if (in_take) begin
            r_in_raw   <= i_raw_touch;
            r_in_sleep <= i_plant_sleeping;
        end
        if (step) begin
            r_out <= core_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_led_on        = r_out.led_on;
    assign o_short_press   = r_out.short_press;
    assign o_long_press    = r_out.long_press;
    assign o_wake_request  = r_out.wake_request;
    assign o_dialog_exit   = r_out.dialog_exit;
    assign o_interaction   = r_out.interaction;
    assign o_clear_bubble  = r_out.clear_bubble;
    assign o_frame_show    = r_out.frame_show;
    assign o_frame_index   = r_out.frame_index;
    assign o_dialog_active = r_out.dialog_active;

endmodule

// ===== hdl/tslpd_chk.sv =====
`include "touch_short_long_press_detector_defines.svh"

module tslpd_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic       o_short_press,
    input logic       o_long_press,
    input logic       o_wake_request,
    input logic       o_dialog_exit,
    input logic       o_interaction,
    input logic       o_clear_bubble,
    input logic       o_frame_show,
    input logic [1:0] o_frame_index,
    input logic       o_dialog_active
);

    // every event pulse counts as an interaction
    `TSLPD_AST_NOW(a_event_interaction, o_out_valid && (o_short_press || o_long_press || o_wake_request || o_dialog_exit), o_interaction)

    // entering dialog clears the bubble and shows frame zero
    `TSLPD_AST_NOW(a_long_enters_dialog, o_out_valid && o_long_press, o_clear_bubble && o_frame_show && o_dialog_active && (o_frame_index == 2'd0))

    // outside dialog the animation sits at frame zero
    `TSLPD_AST_NOW(a_idle_frame_zero, o_out_valid && !o_dialog_active, o_frame_index == 2'd0)

    // a stalled result holds
    `TSLPD_AST_NXT(a_stall_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_frame_index) && $stable(o_interaction))

endmodule

bind touch_short_long_press_detector tslpd_chk u_tslpd_chk (.*);
